[rtl/assert_macros.svh]
// Assertion macros for the cuckoo hash table RTL.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CHT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/cht_pkg.sv]
// Package for the cuckoo hash table: field widths, defaults, codes, helpers.
// No dependencies.
package cht_pkg;

    localparam int DEF_HASH_POWER       = 10;
    localparam int DEF_SLOTS_PER_BUCKET = 4;
    localparam int DEF_SEARCH_PATHS     = 2;
    localparam int DEF_MAX_KICKS        = 128;
    localparam int DEF_KEY_BITS         = 64;
    localparam int DEF_VALUE_BITS       = 32;

    localparam int REQ_W   = 2;
    localparam int HASH_W  = 32;
    localparam int KEYW_W  = 64;
    localparam int LEN_W   = 4;
    localparam int VAL_W   = 32;
    localparam int TAG_W   = 8;
    localparam int LFSR_W  = 16;
    localparam int RES_W   = 4;

    localparam logic [31:0]       ALT_MULT  = 32'h5bd1e995;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

    localparam logic [REQ_W-1:0] REQ_FIND   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

    // Fibonacci LFSR, taps 16,14,13,11.
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
        logic fb;
        fb = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {fb, v[LFSR_W-1:1]};
    endfunction

    // Fold eight more bits, MSB first, into a running residue below modulus.
    function automatic logic [RES_W-1:0] mod_fold8(input logic [RES_W-1:0] r_in,
                                                   input logic [7:0] bits,
                                                   input logic [RES_W-1:0] modulus);
        logic [RES_W-1:0] r;
        r = r_in;
        for (int i = 7; i >= 0; i--) begin
            r = {r[RES_W-2:0], bits[i]};
            if (r >= modulus)
                r = r - modulus;
        end
        return r;
    endfunction

endpackage

[rtl/cht_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

[rtl/cuckoo_hash_table.sv]
// Cuckoo hash table top level: request sequencer over slot and path memories.
// Depends on cht_pkg, cht_ram and assert_macros.svh.
//
// Usage: a request (req_type, key_hash, key_word, key_len, entry_value) is
// taken when in_valid is high and in_stall is low. Every request gives one
// result (success, found_value), offered with out_valid until out_stall is low.
// The block works on one request at a time; in_stall is low only while it idles.
// A new request is taken while an earlier result still waits at the output.
// Each slot visit is a registered memory read followed by a check state, for
// find, delete and an insert into a free slot alike; an unknown request goes
// straight to its result. A displacing insert walks its search levels and
// moves entries back along the path it found, bounded by MAX_KICKS.
// After reset a clearing pass empties every slot, one per cycle; in_stall
// stays high meanwhile. When out_stall holds, the result holds and the block
// finishes the next request only once the output register is free.
module cuckoo_hash_table #(
    parameter int HASH_POWER       = cht_pkg::DEF_HASH_POWER,
    parameter int SLOTS_PER_BUCKET = cht_pkg::DEF_SLOTS_PER_BUCKET,
    parameter int SEARCH_PATHS     = cht_pkg::DEF_SEARCH_PATHS,
    parameter int MAX_KICKS        = cht_pkg::DEF_MAX_KICKS,
    parameter int KEY_BITS         = cht_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS       = cht_pkg::DEF_VALUE_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [cht_pkg::REQ_W-1:0]   req_type,
    input  logic [cht_pkg::HASH_W-1:0]  key_hash,
    input  logic [cht_pkg::KEYW_W-1:0]  key_word,
    input  logic [cht_pkg::LEN_W-1:0]   key_len,
    input  logic [cht_pkg::VAL_W-1:0]   entry_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        success,
    output logic [cht_pkg::VAL_W-1:0]   found_value
);

    import cht_pkg::*;

`include "assert_macros.svh"

    localparam int SLOT_W     = $clog2(SLOTS_PER_BUCKET);
    localparam int SADDR_W    = HASH_POWER + SLOT_W;
    localparam int SDEPTH     = 1 << SADDR_W;
    localparam int ENT_W      = 1 + TAG_W + LEN_W + VALUE_BITS + KEY_BITS;
    localparam int V_POS      = ENT_W - 1;
    localparam int TAG_LSB    = ENT_W - 1 - TAG_W;
    localparam int LEN_LSB    = KEY_BITS + VALUE_BITS;
    localparam int VAL_LSB    = KEY_BITS;
    localparam int REC_W      = SLOT_W + ENT_W;
    localparam int PDEPTH     = MAX_KICKS * SEARCH_PATHS;
    localparam int PIDX_W     = $clog2(PDEPTH);
    localparam int DEPTH_W    = $clog2(MAX_KICKS);
    localparam int KICK_W     = $clog2(MAX_KICKS + SEARCH_PATHS + 1);
    localparam int P_W        = $clog2(SEARCH_PATHS);
    localparam int HALF_PATHS = SEARCH_PATHS / 2;

    localparam logic [4:0] S_CLEAR  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_LK_RD  = 5'd2;
    localparam logic [4:0] S_LK_CHK = 5'd3;
    localparam logic [4:0] S_AD_RD  = 5'd4;
    localparam logic [4:0] S_AD_CHK = 5'd5;
    localparam logic [4:0] S_PI_WR  = 5'd6;
    localparam logic [4:0] S_PS_TOP = 5'd7;
    localparam logic [4:0] S_PB_RD  = 5'd8;
    localparam logic [4:0] S_PB_LAT = 5'd9;
    localparam logic [4:0] S_PS_RD  = 5'd10;
    localparam logic [4:0] S_PS_CHK = 5'd11;
    localparam logic [4:0] S_VIC1   = 5'd12;
    localparam logic [4:0] S_VIC2   = 5'd13;
    localparam logic [4:0] S_VR_RD  = 5'd14;
    localparam logic [4:0] S_VR_CHK = 5'd15;
    localparam logic [4:0] S_MB_TOP = 5'd16;
    localparam logic [4:0] S_MB_RDA = 5'd17;
    localparam logic [4:0] S_MB_LA  = 5'd18;
    localparam logic [4:0] S_MB_RDC = 5'd19;
    localparam logic [4:0] S_MB_LC  = 5'd20;
    localparam logic [4:0] S_MB_RS  = 5'd21;
    localparam logic [4:0] S_MB_CS  = 5'd22;
    localparam logic [4:0] S_MB_RD  = 5'd23;
    localparam logic [4:0] S_MB_CD  = 5'd24;
    localparam logic [4:0] S_MB_CLR = 5'd25;
    localparam logic [4:0] S_FB_RD  = 5'd26;
    localparam logic [4:0] S_FB_LAT = 5'd27;
    localparam logic [4:0] S_DONE   = 5'd28;

    // Byte mask for the low min(len,8) key bytes.
    function automatic logic [KEYW_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [KEYW_W-1:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < int'(len))
                m[i*8 +: 8] = 8'hFF;
        end
        return m;
    endfunction

    function automatic logic [HASH_POWER-1:0] alt_bucket(input logic [HASH_POWER-1:0] b,
                                                         input logic [TAG_W-1:0] t);
        logic [39:0] prod;
        prod = 40'(t) * 40'(ALT_MULT);
        return b ^ prod[HASH_POWER-1:0];
    endfunction

    // Control registers
    logic [4:0]         state_reg, state_next;
    logic [SADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [LFSR_W-1:0]  lfsr_reg, lfsr_next;
    logic               out_valid_reg, out_valid_next;
    logic               k_reg, k_next;
    logic               final_reg, final_next;
    logic [SLOT_W-1:0]  s_reg, s_next;
    logic [P_W-1:0]     p_reg, p_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [DEPTH_W-1:0] md_reg, md_next;
    logic [KICK_W-1:0]  kick_reg, kick_next;

    // Payload registers
    logic [REQ_W-1:0]      req_reg, req_next;
    logic [HASH_POWER-1:0] b0_reg, b0_next;
    logic [HASH_POWER-1:0] b1_reg, b1_next;
    logic [TAG_W-1:0]      tag_reg, tag_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [HASH_POWER-1:0] scan_bkt_reg, scan_bkt_next;
    logic [RES_W-1:0]      res_reg, res_next;
    logic [HASH_POWER-1:0] src_bkt_reg, src_bkt_next;
    logic [SLOT_W-1:0]     src_slot_reg, src_slot_next;
    logic [HASH_POWER-1:0] dst_bkt_reg, dst_bkt_next;
    logic [SLOT_W-1:0]     dst_slot_reg, dst_slot_next;
    logic [ENT_W-1:0]      ent_reg, ent_next;
    logic                  res_ok_reg, res_ok_next;
    logic [VAL_W-1:0]      res_val_reg, res_val_next;
    logic                  success_reg, success_next;
    logic [VAL_W-1:0]      found_reg, found_next;

    // Memory ports
    logic               slot_we;
    logic [SADDR_W-1:0] slot_waddr, slot_raddr;
    logic [ENT_W-1:0]   slot_wdata, slot_rdata;
    logic               pb_we;
    logic [PIDX_W-1:0]  pb_waddr;
    logic [HASH_POWER-1:0] pb_wdata, pb_rdata;
    logic               rec_we;
    logic [REC_W-1:0]   rec_wdata, rec_rdata;
    logic               slot_rd_live;

    logic [DEPTH_W-1:0] lvl;
    logic [PIDX_W-1:0]  pidx, pidx_up;
    logic [KEYW_W-1:0]  in_key_m;
    logic [TAG_W-1:0]   in_tag;
    logic [HASH_POWER-1:0] in_b0;
    logic [ENT_W-1:0]   new_entry;
    logic               rd_valid, key_hit, s_last, p_last;

    cht_ram #(.WIDTH(ENT_W), .DEPTH(SDEPTH)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    cht_ram #(.WIDTH(HASH_POWER), .DEPTH(PDEPTH)) u_path_bkt_ram (
        .clk   (clk),
        .we    (pb_we),
        .waddr (pb_waddr),
        .wdata (pb_wdata),
        .raddr (pidx),
        .rdata (pb_rdata)
    );

    cht_ram #(.WIDTH(REC_W), .DEPTH(PDEPTH)) u_path_rec_ram (
        .clk   (clk),
        .we    (rec_we),
        .waddr (pidx),
        .wdata (rec_wdata),
        .raddr (pidx),
        .rdata (rec_rdata)
    );

    // Request decode
    assign in_key_m  = key_word & len_mask(key_len);
    assign in_tag    = (key_hash[TAG_W-1:0] == '0) ? TAG_W'(1) : key_hash[TAG_W-1:0];
    assign in_b0     = key_hash[HASH_W-1 -: HASH_POWER];
    assign new_entry = {1'b1, tag_reg, len_reg, val_reg, key_reg};

    assign rd_valid = slot_rdata[V_POS];
    assign key_hit  = rd_valid && (slot_rdata[LEN_LSB +: LEN_W] == len_reg) &&
                      (slot_rdata[KEY_BITS-1:0] == key_reg);
    assign s_last   = (s_reg == SLOT_W'(SLOTS_PER_BUCKET - 1));
    assign p_last   = (p_reg == P_W'(SEARCH_PATHS - 1));

    // Path memory index: level * SEARCH_PATHS + path
    always_comb
    begin
        priority if (state_reg == S_MB_RDA)
            lvl = md_reg - DEPTH_W'(1);
        else if (state_reg == S_MB_RDC)
            lvl = md_reg;
        else if (state_reg == S_FB_RD || state_reg == S_PI_WR)
            lvl = '0;
        else
            lvl = depth_reg;
    end

    assign pidx    = PIDX_W'(int'(lvl) * SEARCH_PATHS + int'(p_reg));
    assign pidx_up = PIDX_W'(int'(pidx) + SEARCH_PATHS);

    assign slot_rd_live = (state_reg == S_LK_RD) || (state_reg == S_AD_RD) ||
                          (state_reg == S_PS_RD) || (state_reg == S_VR_RD) ||
                          (state_reg == S_MB_RS) || (state_reg == S_MB_RD);

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        lfsr_next     = lfsr_reg;
        out_valid_next = out_valid_reg;
        k_next        = k_reg;
        final_next    = final_reg;
        s_next        = s_reg;
        p_next        = p_reg;
        depth_next    = depth_reg;
        md_next       = md_reg;
        kick_next     = kick_reg;
        req_next      = req_reg;
        b0_next       = b0_reg;
        b1_next       = b1_reg;
        tag_next      = tag_reg;
        len_next      = len_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        scan_bkt_next = scan_bkt_reg;
        res_next      = res_reg;
        src_bkt_next  = src_bkt_reg;
        src_slot_next = src_slot_reg;
        dst_bkt_next  = dst_bkt_reg;
        dst_slot_next = dst_slot_reg;
        ent_next      = ent_reg;
        res_ok_next   = res_ok_reg;
        res_val_next  = res_val_reg;
        success_next  = success_reg;
        found_next    = found_reg;

        slot_we    = 1'b0;
        slot_waddr = {scan_bkt_reg, s_reg};
        slot_wdata = new_entry;
        slot_raddr = {scan_bkt_reg, s_reg};
        pb_we      = 1'b0;
        pb_waddr   = pidx;
        pb_wdata   = b0_reg;
        rec_we     = 1'b0;
        rec_wdata  = {s_reg, slot_rdata};

        // Drop the result once the receiver takes it.
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                slot_we      = 1'b1;
                slot_waddr   = clr_cnt_reg;
                slot_wdata   = '0;
                clr_cnt_next = clr_cnt_reg + SADDR_W'(1);
                if (&clr_cnt_reg)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next      = req_type;
                    b0_next       = in_b0;
                    b1_next       = alt_bucket(in_b0, in_tag);
                    tag_next      = in_tag;
                    len_next      = key_len;
                    key_next      = KEY_BITS'(in_key_m);
                    val_next      = VALUE_BITS'(entry_value);
                    scan_bkt_next = in_b0;
                    k_next        = 1'b0;
                    final_next    = 1'b0;
                    s_next        = '0;
                    res_ok_next   = 1'b0;
                    res_val_next  = '0;
                    priority if (req_type == REQ_FIND || req_type == REQ_DELETE)
                        state_next = S_LK_RD;
                    else if (req_type == REQ_INSERT)
                        state_next = S_AD_RD;
                    else
                        state_next = S_DONE;
                end
            end
            S_LK_RD:
                state_next = S_LK_CHK;
            S_LK_CHK:
            begin
                if (key_hit)
                begin
                    res_ok_next = 1'b1;
                    if (req_reg == REQ_FIND)
                        res_val_next = VAL_W'(slot_rdata[VAL_LSB +: VALUE_BITS]);
                    else
                    begin
                        slot_we    = 1'b1;
                        slot_wdata = '0;
                    end
                    state_next = S_DONE;
                end
                else if (s_last)
                begin
                    if (!k_reg)
                    begin
                        k_next        = 1'b1;
                        scan_bkt_next = b1_reg;
                        s_next        = '0;
                        state_next    = S_LK_RD;
                    end
                    else
                        state_next = S_DONE;
                end
                else
                begin
                    s_next     = s_reg + SLOT_W'(1);
                    state_next = S_LK_RD;
                end
            end
            S_AD_RD:
                state_next = S_AD_CHK;
            S_AD_CHK:
            begin
                if (!rd_valid)
                begin
                    slot_we     = 1'b1;
                    res_ok_next = 1'b1;
                    state_next  = S_DONE;
                end
                else if (s_last)
                begin
                    if (final_reg)
                        state_next = S_DONE;
                    else if (!k_reg)
                    begin
                        k_next        = 1'b1;
                        scan_bkt_next = b1_reg;
                        s_next        = '0;
                        state_next    = S_AD_RD;
                    end
                    else
                    begin
                        p_next     = '0;
                        state_next = S_PI_WR;
                    end
                end
                else
                begin
                    s_next     = s_reg + SLOT_W'(1);
                    state_next = S_AD_RD;
                end
            end
            S_PI_WR:
            begin
                // Seed the path roots: first half at the primary bucket.
                pb_we    = 1'b1;
                pb_wdata = (p_reg < P_W'(HALF_PATHS)) ? b0_reg : b1_reg;
                if (p_last)
                begin
                    depth_next = '0;
                    kick_next  = '0;
                    state_next = S_PS_TOP;
                end
                else
                    p_next = p_reg + P_W'(1);
            end
            S_PS_TOP:
            begin
                if (kick_reg >= KICK_W'(MAX_KICKS) || depth_reg >= DEPTH_W'(MAX_KICKS - 1))
                    state_next = S_DONE;
                else
                begin
                    p_next     = '0;
                    state_next = S_PB_RD;
                end
            end
            S_PB_RD:
                state_next = S_PB_LAT;
            S_PB_LAT:
            begin
                scan_bkt_next = pb_rdata;
                s_next        = '0;
                state_next    = S_PS_RD;
            end
            S_PS_RD:
                state_next = S_PS_CHK;
            S_PS_CHK:
            begin
                if (!rd_valid)
                begin
                    // Free slot ends this path; walk it back from here.
                    rec_we     = 1'b1;
                    md_next    = depth_reg;
                    state_next = S_MB_TOP;
                end
                else if (s_last)
                    state_next = S_VIC1;
                else
                begin
                    s_next     = s_reg + SLOT_W'(1);
                    state_next = S_PS_RD;
                end
            end
            S_VIC1:
            begin
                lfsr_next  = lfsr_step(lfsr_reg);
                res_next   = mod_fold8('0, lfsr_next[15:8], RES_W'(SLOTS_PER_BUCKET));
                state_next = S_VIC2;
            end
            S_VIC2:
            begin
                s_next = SLOT_W'(mod_fold8(res_reg, lfsr_reg[7:0],
                                           RES_W'(SLOTS_PER_BUCKET)));
                state_next = S_VR_RD;
            end
            S_VR_RD:
                state_next = S_VR_CHK;
            S_VR_CHK:
            begin
                // Record the victim and the bucket it would move to.
                rec_we   = 1'b1;
                pb_we    = 1'b1;
                pb_waddr = pidx_up;
                pb_wdata = alt_bucket(scan_bkt_reg, slot_rdata[TAG_LSB +: TAG_W]);
                if (p_last)
                begin
                    kick_next  = kick_reg + KICK_W'(SEARCH_PATHS);
                    depth_next = depth_reg + DEPTH_W'(1);
                    state_next = S_PS_TOP;
                end
                else
                begin
                    p_next     = p_reg + P_W'(1);
                    state_next = S_PB_RD;
                end
            end
            S_MB_TOP:
            begin
                if (md_reg == '0)
                    state_next = S_FB_RD;
                else
                    state_next = S_MB_RDA;
            end
            S_MB_RDA:
                state_next = S_MB_LA;
            S_MB_LA:
            begin
                src_bkt_next  = pb_rdata;
                src_slot_next = rec_rdata[ENT_W +: SLOT_W];
                ent_next      = rec_rdata[ENT_W-1:0];
                state_next    = S_MB_RDC;
            end
            S_MB_RDC:
                state_next = S_MB_LC;
            S_MB_LC:
            begin
                dst_bkt_next  = pb_rdata;
                dst_slot_next = rec_rdata[ENT_W +: SLOT_W];
                state_next    = S_MB_RS;
            end
            S_MB_RS:
            begin
                slot_raddr = {src_bkt_reg, src_slot_reg};
                state_next = S_MB_CS;
            end
            S_MB_CS:
            begin
                // Stale source: search again one level shallower.
                if (!(rd_valid && slot_rdata == ent_reg))
                begin
                    depth_next = md_reg - DEPTH_W'(1);
                    state_next = S_PS_TOP;
                end
                else
                    state_next = S_MB_RD;
            end
            S_MB_RD:
            begin
                slot_raddr = {dst_bkt_reg, dst_slot_reg};
                state_next = S_MB_CD;
            end
            S_MB_CD:
            begin
                if (rd_valid)
                begin
                    depth_next = md_reg - DEPTH_W'(1);
                    state_next = S_PS_TOP;
                end
                else
                begin
                    slot_we    = 1'b1;
                    slot_waddr = {dst_bkt_reg, dst_slot_reg};
                    slot_wdata = ent_reg;
                    state_next = S_MB_CLR;
                end
            end
            S_MB_CLR:
            begin
                slot_we    = 1'b1;
                slot_waddr = {src_bkt_reg, src_slot_reg};
                slot_wdata = '0;
                md_next    = md_reg - DEPTH_W'(1);
                state_next = S_MB_TOP;
            end
            S_FB_RD:
                state_next = S_FB_LAT;
            S_FB_LAT:
            begin
                scan_bkt_next = pb_rdata;
                s_next        = '0;
                final_next    = 1'b1;
                state_next    = S_AD_RD;
            end
            S_DONE:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    success_next   = res_ok_reg;
                    found_next     = res_val_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            lfsr_reg      <= LFSR_SEED;
            out_valid_reg <= 1'b0;
            k_reg         <= 1'b0;
            final_reg     <= 1'b0;
            s_reg         <= '0;
            p_reg         <= '0;
            depth_reg     <= '0;
            md_reg        <= '0;
            kick_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            lfsr_reg      <= lfsr_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            final_reg     <= final_next;
            s_reg         <= s_next;
            p_reg         <= p_next;
            depth_reg     <= depth_next;
            md_reg        <= md_next;
            kick_reg      <= kick_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        b0_reg       <= b0_next;
        b1_reg       <= b1_next;
        tag_reg      <= tag_next;
        len_reg      <= len_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        scan_bkt_reg <= scan_bkt_next;
        res_reg      <= res_next;
        src_bkt_reg  <= src_bkt_next;
        src_slot_reg <= src_slot_next;
        dst_bkt_reg  <= dst_bkt_next;
        dst_slot_reg <= dst_slot_next;
        ent_reg      <= ent_next;
        res_ok_reg   <= res_ok_next;
        res_val_reg  <= res_val_next;
        success_reg  <= success_next;
        found_reg    <= found_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign success     = success_reg;
    assign found_value = found_reg;

    `CHT_ASSERT_NXT(a_accept_busy, in_valid && !in_stall, in_stall, "request accepted but block idles")
    `CHT_ASSERT_IMP(a_miss_zero, out_valid && !success, found_value == '0, "miss with nonzero value")
    `CHT_ASSERT_IMP(a_no_rw_clash, slot_we && slot_rd_live, slot_waddr != slot_raddr, "slot read/write clash")
    `CHT_ASSERT_IMP(a_depth_bound, state_reg == S_PS_RD, depth_reg < DEPTH_W'(MAX_KICKS - 1), "search too deep")

endmodule
